// ===== rtl/core/wsmd_pkg.sv =====
// shared types and constants of the wav stream mono decoder
package wsmd_pkg;

  localparam int unsigned MAX_FRAME_BYTES   = 512;
  localparam int unsigned FMT_CAPTURE_BYTES = 40;
  localparam int unsigned DIV_W             = 41;
  localparam int unsigned DIVR_W            = 16;
  localparam int unsigned DIV_CNT_W         = $clog2(DIV_W + 1);

  localparam logic [15:0] FMT_PCM   = 16'h0001;
  localparam logic [15:0] FMT_FLOAT = 16'h0003;
  localparam logic [15:0] FMT_EXT   = 16'hFFFE;
  localparam logic [31:0] TAG_FMT   = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA  = 32'h6174_6164;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_INFO   = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [2:0] ERR_NOT_WAV     = 3'd0;
  localparam logic [2:0] ERR_BAD_FMT     = 3'd1;
  localparam logic [2:0] ERR_NO_DATA     = 3'd2;
  localparam logic [2:0] ERR_UNSUPPORTED = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED   = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } wsmd_in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] sample;
    logic [31:0]        sample_rate;
    logic [31:0]        frames_available;
    logic [23:0]        samples_written;
    logic [2:0]         error_code;
  } wsmd_out_t;

  typedef struct packed {
    logic              start;
    logic              neg;
    logic [DIV_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/core/wsmd_div.sv =====
// iterative restoring divider, one quotient bit per cycle, truncating toward zero
module wsmd_div import wsmd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIVR_W-1:0]    rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DIVR_W-1:0]    dvs_q, dvs_d;
  logic                 neg_q, neg_d;
  logic                 done_q, done_d;
  logic [DIVR_W:0]      rem_sh;
  logic                 fits;

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    rem_sh = {rem_q, quo_q[DIV_W-1]};
    fits   = rem_sh >= {1'b0, dvs_q};
    if (req_i.start) begin
      cnt_d = DIV_CNT_W'(DIV_W);
      rem_d = '0;
      quo_d = req_i.dividend;
      dvs_d = req_i.divisor;
      neg_d = req_i.neg;
    end else if (cnt_q != '0) begin
      rem_d = fits ? DIVR_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DIVR_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? DIV_W'(-quo_q) : quo_q;

endmodule

// ===== rtl/core/wav_stream_mono_decoder_unit.sv =====
// wav byte stream parser and mono q1.31 sample decoder, top level
//
//  channel | signals                          | transaction
//  in      | in_valid_i in_stall_o in_data_i  | one file byte with first/last flags
//  out     | out_valid_o out_stall_i out_data_o | sample, info, finished or error
//  cfg     | cfg_we_i cfg_wdata_i             | sample cap write
//
//  a byte passes ST_PARSE and ST_FIN; a chunk header's last byte also ST_START
//  a sample's last byte also ST_ACC; a frame's last byte or accepted data chunk header
//  also ST_DIV and ST_POST; results wait in the two-entry buffer while out_stall_i is high
//  in_stall_o stays high from acceptance until the last result, if any, is taken
//  reset clears all parse state and sets the sample cap to all ones
module wav_stream_mono_decoder_unit import wsmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  wsmd_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output wsmd_out_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PARSE = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_ACC   = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_POST  = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;
  localparam logic [2:0] ST_EMIT  = 3'd7;

  localparam logic [2:0] PH_HDR  = 3'd0;
  localparam logic [2:0] PH_CHDR = 3'd1;
  localparam logic [2:0] PH_FMT  = 3'd2;
  localparam logic [2:0] PH_SKIP = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;

  localparam logic OP_INFO   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  function automatic logic [7:0] magic_byte(input logic [3:0] idx);
    logic [7:0] r;
    r = 8'h00;
    unique case (idx)
      4'd0:       r = 8'h52;
      4'd1:       r = 8'h49;
      4'd2, 4'd3: r = 8'h46;
      4'd8:       r = 8'h57;
      4'd9:       r = 8'h41;
      4'd10:      r = 8'h56;
      4'd11:      r = 8'h45;
      default:    r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] float_q31(input logic [31:0] u);
    logic [7:0]  e;
    logic [23:0] m;
    logic [31:0] mag;
    logic [31:0] sat;
    e   = u[30:23];
    m   = {1'b1, u[22:0]};
    sat = u[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    mag = '0;
    if (e == 8'hFF && u[22:0] != '0) begin
      return '0;
    end
    if (e == 8'h00) begin
      return '0;
    end
    if (e >= 8'd127) begin
      return sat;
    end
    if (e >= 8'd119) begin
      mag = {8'h00, m} << (e - 8'd119);
    end else if (e >= 8'd88) begin
      mag = {8'h00, m} >> (8'd119 - e);
    end
    return u[31] ? 32'(-mag) : mag;
  endfunction

  function automatic wsmd_out_t mk_res(input logic [1:0] kind, input logic [31:0] smp,
                                       input logic [31:0] rate, input logic [31:0] frames,
                                       input logic [23:0] wr, input logic [2:0] err);
    wsmd_out_t r;
    r.kind             = kind;
    r.sample           = smp;
    r.sample_rate      = rate;
    r.frames_available = frames;
    r.samples_written  = wr;
    r.error_code       = err;
    return r;
  endfunction

  logic [2:0]         state_q, state_d;
  logic [2:0]         phase_q, phase_d;
  logic [31:0]        bc_q, bc_d;
  logic [31:0]        tag_q, tag_d;
  logic [31:0]        size_q, size_d;
  logic [15:0]        ftag_q, ftag_d;
  logic [15:0]        ch_q, ch_d;
  logic [15:0]        bits_q, bits_d;
  logic [31:0]        rate_q, rate_d;
  logic               fmtv_q, fmtv_d;
  logic [31:0]        sa_q, sa_d;
  logic [9:0]         ci_q, ci_d;
  logic signed [40:0] fs_q, fs_d;
  logic [31:0]        fl_q, fl_d;
  logic [23:0]        so_q, so_d;
  logic [23:0]        max_q;
  logic               op_q, op_d;
  logic [1:0]         cnt_q, cnt_d;
  logic               idx_q, idx_d;
  logic               last_q, last_d;
  logic [7:0]         byte_q, byte_d;
  logic [31:0]        raw_q, raw_d;
  wsmd_out_t          slot0_q, slot0_d, slot1_q, slot1_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  wsmd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic [32:0]        body_total;
  logic [31:0]        take;
  logic [31:0]        bc_inc;
  logic [15:0]        ftag_n, ch_n, bits_n;
  logic [31:0]        rate_n, sa_n;
  logic               fmt_ok;
  logic [17:0]        fb;
  logic signed [40:0] fs_n;
  logic [9:0]         ci_n;
  logic [23:0]        so_n;
  logic [31:0]        fl_n;
  logic [1:0]         cnt_n;
  logic [2:0]         err_n;
  logic               mismatch;

  assign body_total = {1'b0, size_q} + {32'b0, size_q[0]};
  assign take       = (size_q < 32'(FMT_CAPTURE_BYTES)) ? size_q : 32'(FMT_CAPTURE_BYTES);
  assign bc_inc     = bc_q + 32'd1;
  assign mismatch   = ((bc_q < 32'd4) || (bc_q >= 32'd8)) && (byte_q != magic_byte(bc_q[3:0]));
  assign fmt_ok     = (ftag_q == FMT_PCM && (bits_q == 16'd8 || bits_q == 16'd16 ||
                       bits_q == 16'd24 || bits_q == 16'd32)) ||
                      (ftag_q == FMT_FLOAT && bits_q == 16'd32);

  always_comb begin
    unique case (bits_q)
      16'd8:   fb = {2'b00, ch_q};
      16'd16:  fb = {1'b0, ch_q, 1'b0};
      16'd24:  fb = {1'b0, ch_q, 1'b0} + {2'b00, ch_q};
      default: fb = {ch_q, 2'b00};
    endcase
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    bc_d    = bc_q;
    tag_d   = tag_q;
    size_d  = size_q;
    ftag_d  = ftag_q;
    ch_d    = ch_q;
    bits_d  = bits_q;
    rate_d  = rate_q;
    fmtv_d  = fmtv_q;
    sa_d    = sa_q;
    ci_d    = ci_q;
    fs_d    = fs_q;
    fl_d    = fl_q;
    so_d    = so_q;
    op_d    = op_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    last_d  = last_q;
    byte_d  = byte_q;
    raw_d   = raw_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    div_req = '0;
    ftag_n  = ftag_q;
    ch_n    = ch_q;
    bits_n  = bits_q;
    rate_n  = rate_q;
    sa_n    = sa_q | ({24'b0, byte_q} << {bc_q[1:0], 3'b000});
    fs_n    = fs_q + {{9{raw_q[31]}}, raw_q};
    ci_n    = ci_q + 10'd1;
    so_n    = so_q + 24'd1;
    fl_n    = fl_q - 32'd1;
    cnt_n   = cnt_q;
    err_n   = ERR_NO_DATA;

    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        idx_d = 1'b0;
        if (in_valid_i) begin
          byte_d  = in_data_i.data_byte;
          last_d  = in_data_i.last_byte;
          state_d = ST_PARSE;
          if (in_data_i.first_byte) begin
            phase_d = PH_HDR;
            bc_d    = '0;
            tag_d   = '0;
            size_d  = '0;
            ftag_d  = '0;
            ch_d    = '0;
            bits_d  = '0;
            rate_d  = '0;
            fmtv_d  = 1'b0;
            sa_d    = '0;
            ci_d    = '0;
            fs_d    = '0;
            fl_d    = '0;
            so_d    = '0;
          end
        end
      end
      ST_PARSE: begin
        state_d = ST_FIN;
        unique case (phase_q)
          PH_HDR: begin
            if (mismatch) begin
              slot0_d = mk_res(KIND_ERROR, '0, '0, '0, '0, ERR_NOT_WAV);
              cnt_d   = 2'd1;
              phase_d = PH_DONE;
            end else if (bc_q == 32'd11) begin
              bc_d    = '0;
              phase_d = PH_CHDR;
            end else begin
              bc_d = bc_inc;
            end
          end
          PH_CHDR: begin
            if (bc_q < 32'd4) begin
              tag_d[{bc_q[1:0], 3'b000} +: 8] = byte_q;
            end else begin
              size_d[{bc_q[1:0], 3'b000} +: 8] = byte_q;
            end
            if (bc_q == 32'd7) begin
              state_d = ST_START;
            end else begin
              bc_d = bc_inc;
            end
          end
          PH_FMT: begin
            if (bc_q < 32'd2) begin
              ftag_n = ftag_q | ({8'b0, byte_q} << {bc_q[0], 3'b000});
            end else if (bc_q < 32'd4) begin
              ch_n = ch_q | ({8'b0, byte_q} << {bc_q[0], 3'b000});
            end else if (bc_q < 32'd8) begin
              rate_n = rate_q | ({24'b0, byte_q} << {bc_q[1:0], 3'b000});
            end else if (bc_q == 32'd14 || bc_q == 32'd15) begin
              bits_n = bits_q | ({8'b0, byte_q} << {bc_q[0], 3'b000});
            end else if (bc_q == 32'd24) begin
              sa_d = {24'b0, byte_q};
            end else if (bc_q == 32'd25 && ftag_q == FMT_EXT) begin
              ftag_n = {byte_q, sa_q[7:0]};
            end
            ftag_d = ftag_n;
            ch_d   = ch_n;
            bits_d = bits_n;
            rate_d = rate_n;
            bc_d   = bc_inc;
            if (bc_inc >= take) begin
              sa_d   = '0;
              fmtv_d = (ch_n != '0) && (bits_n != '0);
              if ({1'b0, bc_inc} >= body_total) begin
                bc_d    = '0;
                phase_d = PH_CHDR;
              end else begin
                phase_d = PH_SKIP;
              end
            end
          end
          PH_SKIP: begin
            if ({1'b0, bc_inc} >= body_total) begin
              bc_d    = '0;
              phase_d = PH_CHDR;
            end else begin
              bc_d = bc_inc;
            end
          end
          PH_DATA: begin
            if (bc_inc < {29'b0, bits_q[5:3]}) begin
              sa_d = sa_n;
              bc_d = bc_inc;
            end else begin
              priority if (ftag_q == FMT_FLOAT) begin
                raw_d = float_q31(sa_n);
              end else if (bits_q == 16'd8) begin
                raw_d = {sa_n[7:0] ^ 8'h80, 24'b0};
              end else if (bits_q == 16'd16) begin
                raw_d = {sa_n[15:0], 16'b0};
              end else if (bits_q == 16'd24) begin
                raw_d = {sa_n[23:0], 8'b0};
              end else begin
                raw_d = sa_n;
              end
              sa_d    = '0;
              bc_d    = '0;
              state_d = ST_ACC;
            end
          end
          default: begin
          end
        endcase
      end
      ST_START: begin
        bc_d    = '0;
        state_d = ST_FIN;
        unique if (tag_q == TAG_FMT) begin
          ftag_d  = '0;
          ch_d    = '0;
          bits_d  = '0;
          rate_d  = '0;
          fmtv_d  = 1'b0;
          phase_d = (size_q == '0) ? PH_CHDR : PH_FMT;
        end else if (tag_q == TAG_DATA) begin
          if (!fmtv_q) begin
            slot0_d = mk_res(KIND_ERROR, '0, '0, '0, '0, ERR_BAD_FMT);
            cnt_d   = 2'd1;
            phase_d = PH_DONE;
          end else if (!fmt_ok || fb > 18'(MAX_FRAME_BYTES)) begin
            slot0_d = mk_res(KIND_ERROR, '0, '0, '0, '0, ERR_UNSUPPORTED);
            cnt_d   = 2'd1;
            phase_d = PH_DONE;
          end else begin
            div_req.start    = 1'b1;
            div_req.neg      = 1'b0;
            div_req.dividend = {9'b0, size_q};
            div_req.divisor  = fb[15:0];
            op_d             = OP_INFO;
            state_d          = ST_DIV;
          end
        end else begin
          phase_d = (size_q == '0) ? PH_CHDR : PH_SKIP;
        end
      end
      ST_ACC: begin
        fs_d = fs_n;
        ci_d = ci_n;
        if ({6'b0, ci_n} < ch_q) begin
          state_d = ST_FIN;
        end else begin
          div_req.start    = 1'b1;
          div_req.neg      = fs_n[40];
          div_req.dividend = fs_n[40] ? 41'(-fs_n) : fs_n;
          div_req.divisor  = ch_q;
          op_d             = OP_SAMPLE;
          state_d          = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_POST;
        end
      end
      ST_POST: begin
        state_d = ST_FIN;
        sa_d    = '0;
        ci_d    = '0;
        fs_d    = '0;
        if (op_q == OP_INFO) begin
          slot0_d = mk_res(KIND_INFO, '0, rate_q, div_rsp.quotient[31:0], '0, ERR_NOT_WAV);
          fl_d    = div_rsp.quotient[31:0];
          if (div_rsp.quotient[31:0] == '0 || so_q >= max_q) begin
            slot1_d = mk_res(KIND_DONE, '0, '0, '0, so_q, ERR_NOT_WAV);
            cnt_d   = 2'd2;
            phase_d = PH_DONE;
          end else begin
            cnt_d   = 2'd1;
            phase_d = PH_DATA;
          end
        end else begin
          slot0_d = mk_res(KIND_SAMPLE, div_rsp.quotient[31:0], '0, '0, '0, ERR_NOT_WAV);
          so_d    = so_n;
          fl_d    = fl_n;
          if (fl_n == '0 || so_n >= max_q) begin
            slot1_d = mk_res(KIND_DONE, '0, '0, '0, so_n, ERR_NOT_WAV);
            cnt_d   = 2'd2;
            phase_d = PH_DONE;
          end else begin
            cnt_d = 2'd1;
          end
        end
      end
      ST_FIN: begin
        if (last_q && phase_q != PH_DONE) begin
          unique case (phase_q)
            PH_HDR:  err_n = ERR_NOT_WAV;
            PH_FMT:  err_n = ERR_BAD_FMT;
            PH_DATA: err_n = ERR_TRUNCATED;
            default: err_n = ERR_NO_DATA;
          endcase
          if (cnt_q == 2'd0) begin
            slot0_d = mk_res(KIND_ERROR, '0, '0, '0, '0, err_n);
          end else begin
            slot1_d = mk_res(KIND_ERROR, '0, '0, '0, '0, err_n);
          end
          cnt_n   = cnt_q + 2'd1;
          cnt_d   = cnt_n;
          phase_d = PH_DONE;
        end
        state_d = (cnt_n != 2'd0) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_stall_i) begin
          if (!idx_q && cnt_q == 2'd2) begin
            idx_d = 1'b1;
          end else begin
            idx_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_HDR;
      bc_q    <= '0;
      tag_q   <= '0;
      size_q  <= '0;
      ftag_q  <= '0;
      ch_q    <= '0;
      bits_q  <= '0;
      rate_q  <= '0;
      fmtv_q  <= 1'b0;
      sa_q    <= '0;
      ci_q    <= '0;
      fs_q    <= '0;
      fl_q    <= '0;
      so_q    <= '0;
      max_q   <= 24'hFF_FFFF;
      op_q    <= OP_INFO;
      cnt_q   <= '0;
      idx_q   <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      bc_q    <= bc_d;
      tag_q   <= tag_d;
      size_q  <= size_d;
      ftag_q  <= ftag_d;
      ch_q    <= ch_d;
      bits_q  <= bits_d;
      rate_q  <= rate_d;
      fmtv_q  <= fmtv_d;
      sa_q    <= sa_d;
      ci_q    <= ci_d;
      fs_q    <= fs_d;
      fl_q    <= fl_d;
      so_q    <= so_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    raw_q   <= raw_d;
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign out_data_o  = idx_q ? slot1_q : slot0_q;

  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result is pending");

  a_emit_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cnt_q != 2'd0) && (!idx_q || cnt_q == 2'd2))
    else $error("result buffer read beyond its fill");

  a_div_to_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && div_rsp.done) |=> state_q == ST_POST)
    else $error("divider result not consumed");

  a_accept_parse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == ST_PARSE)
    else $error("accepted byte not parsed");

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ST_DIV)
    else $error("divider finished outside its wait state");

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the wav stream mono decoder
module tb_top;
  import wsmd_pkg::*;

  typedef enum logic [2:0] {
    ST_HEADER, ST_CHUNK_HDR, ST_FMT_BODY, ST_SKIP_BODY, ST_SAMPLES, ST_FINISHED
  } parse_st_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  wsmd_in_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  wsmd_out_t   out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [23:0] cfg_wdata_i = '0;

  wav_stream_mono_decoder_unit u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_wdata_i
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  parse_st_e   st;
  logic [31:0] pos, tag_acc, size_acc, rate_acc, assembly, left_frames;
  logic [15:0] fmt_code, chans, bits;
  logic        fmt_ok;
  logic [9:0]  chan_idx;
  longint      sum_acc;
  logic [23:0] emitted, sample_cap;

  wsmd_out_t   decoded_q[$];
  logic [7:0]  wav_q[$];
  int          mismatches = 0;
  int          bytes_sent = 0;
  int          in_taken = 0;
  bit          calm = 1'b0;

  function automatic void clear_state();
    st = ST_HEADER; pos = 0; tag_acc = 0; size_acc = 0; rate_acc = 0;
    assembly = 0; left_frames = 0; fmt_code = 0; chans = 0; bits = 0;
    fmt_ok = 0; chan_idx = 0; sum_acc = 0; emitted = 0;
  endfunction

  function automatic void expect_result(logic [1:0] k, logic [31:0] s, logic [31:0] r,
                                        logic [31:0] f, logic [23:0] w, logic [2:0] e);
    wsmd_out_t o;
    o.kind = k; o.sample = s; o.sample_rate = r; o.frames_available = f;
    o.samples_written = w; o.error_code = e;
    decoded_q.push_back(o);
  endfunction

  function automatic logic [31:0] float_q31(logic [31:0] u);
    logic [7:0]  e;
    logic [31:0] mag;
    int          sh;
    e = u[30:23];
    if (e == 8'hFF && u[22:0] != 0) return 0;
    if (e == 0) return 0;
    if (e == 8'hFF) return u[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    sh = int'(e) - 119;
    if (sh >= 8) return u[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    mag = {8'd0, 1'b1, u[22:0]};
    if (sh >= 0) mag = mag << sh;
    else if (-sh < 32) mag = mag >> (-sh);
    else mag = 0;
    return u[31] ? -mag : mag;
  endfunction

  function automatic logic [32:0] body_len();
    return {1'b0, size_acc} + size_acc[0];
  endfunction

  function automatic void open_chunk();
    logic [31:0] fb, avail;
    logic        ok;
    pos = 0;
    if (tag_acc == TAG_FMT) begin
      fmt_code = 0; chans = 0; bits = 0; rate_acc = 0; fmt_ok = 0;
      st = (size_acc == 0) ? ST_CHUNK_HDR : ST_FMT_BODY;
    end else if (tag_acc == TAG_DATA) begin
      ok = (fmt_code == FMT_PCM && (bits == 8 || bits == 16 || bits == 24 || bits == 32))
        || (fmt_code == FMT_FLOAT && bits == 32);
      fb = 32'(bits / 8) * 32'(chans);
      if (!fmt_ok) begin
        expect_result(KIND_ERROR, 0, 0, 0, 0, ERR_BAD_FMT); st = ST_FINISHED;
      end else if (!ok || fb > MAX_FRAME_BYTES) begin
        expect_result(KIND_ERROR, 0, 0, 0, 0, ERR_UNSUPPORTED); st = ST_FINISHED;
      end else begin
        avail = size_acc / fb;
        expect_result(KIND_INFO, 0, rate_acc, avail, 0, ERR_NOT_WAV);
        left_frames = avail; assembly = 0; chan_idx = 0; sum_acc = 0;
        if (avail == 0 || emitted >= sample_cap) begin
          expect_result(KIND_DONE, 0, 0, 0, emitted, ERR_NOT_WAV); st = ST_FINISHED;
        end else st = ST_SAMPLES;
      end
    end else st = (body_len() == 0) ? ST_CHUNK_HDR : ST_SKIP_BODY;
  endfunction

  function automatic void decode_byte(wsmd_in_t d);
    logic [7:0]  b, magic;
    logic [31:0] take, raw;
    b = d.data_byte;
    if (d.first_byte) clear_state();
    case (st)
      ST_HEADER: begin
        case (pos)
          0: magic = "R"; 1: magic = "I"; 2, 3: magic = "F";
          8: magic = "W"; 9: magic = "A"; 10: magic = "V"; default: magic = "E";
        endcase
        if ((pos < 4 || pos >= 8) && b != magic) begin
          expect_result(KIND_ERROR, 0, 0, 0, 0, ERR_NOT_WAV); st = ST_FINISHED;
        end else begin
          pos++;
          if (pos >= 12) begin pos = 0; st = ST_CHUNK_HDR; end
        end
      end
      ST_CHUNK_HDR: begin
        if (pos < 4) tag_acc[8*pos +: 8] = b;
        else size_acc[8*(pos-4) +: 8] = b;
        pos++;
        if (pos >= 8) open_chunk();
      end
      ST_FMT_BODY: begin
        take = (size_acc < FMT_CAPTURE_BYTES) ? size_acc : FMT_CAPTURE_BYTES;
        if (pos < 2) fmt_code[8*pos +: 8] = b;
        else if (pos < 4) chans[8*(pos-2) +: 8] = b;
        else if (pos < 8) rate_acc[8*(pos-4) +: 8] = b;
        else if (pos == 14 || pos == 15) bits[8*(pos-14) +: 8] = b;
        else if (pos == 24) assembly = {24'd0, b};
        else if (pos == 25 && fmt_code == FMT_EXT) fmt_code = {b, assembly[7:0]};
        pos++;
        if (pos >= take) begin
          assembly = 0;
          fmt_ok = chans != 0 && bits != 0;
          if ({1'b0, pos} >= body_len()) begin pos = 0; st = ST_CHUNK_HDR; end
          else st = ST_SKIP_BODY;
        end
      end
      ST_SKIP_BODY: begin
        if ({1'b0, pos} + 1 >= body_len()) begin pos = 0; st = ST_CHUNK_HDR; end
        else pos++;
      end
      ST_SAMPLES: begin
        assembly[8*pos[1:0] +: 8] = b;
        pos++;
        if (pos >= 32'(bits / 8)) begin
          if (fmt_code == FMT_FLOAT) raw = float_q31(assembly);
          else case (bits)
            8:  raw = {assembly[7:0] ^ 8'h80, 24'd0};
            16: raw = {assembly[15:0], 16'd0};
            24: raw = {assembly[23:0], 8'd0};
            default: raw = assembly;
          endcase
          sum_acc += longint'(signed'(raw));
          assembly = 0; pos = 0; chan_idx++;
          if (chan_idx >= chans) begin
            expect_result(KIND_SAMPLE, 32'(sum_acc / longint'(chans)), 0, 0, 0, ERR_NOT_WAV);
            chan_idx = 0; sum_acc = 0; emitted++; left_frames--;
            if (left_frames == 0 || emitted >= sample_cap) begin
              expect_result(KIND_DONE, 0, 0, 0, emitted, ERR_NOT_WAV); st = ST_FINISHED;
            end
          end
        end
      end
      default: ;
    endcase
    if (d.last_byte && st != ST_FINISHED) begin
      case (st)
        ST_HEADER:   expect_result(KIND_ERROR, 0, 0, 0, 0, ERR_NOT_WAV);
        ST_FMT_BODY: expect_result(KIND_ERROR, 0, 0, 0, 0, ERR_BAD_FMT);
        ST_SAMPLES:  expect_result(KIND_ERROR, 0, 0, 0, 0, ERR_TRUNCATED);
        default:     expect_result(KIND_ERROR, 0, 0, 0, 0, ERR_NO_DATA);
      endcase
      st = ST_FINISHED;
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  // transaction counters and output checking
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_taken++;
    if (out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) report_mismatch("unexpected result kind", out_data_o.kind, 0);
      else begin
        wsmd_out_t w;
        w = decoded_q.pop_front();
        if (out_data_o.kind != w.kind) report_mismatch("kind", out_data_o.kind, w.kind);
        if (out_data_o.sample != w.sample) report_mismatch("sample", out_data_o.sample, w.sample);
        if (out_data_o.sample_rate != w.sample_rate)
          report_mismatch("sample_rate", out_data_o.sample_rate, w.sample_rate);
        if (out_data_o.frames_available != w.frames_available)
          report_mismatch("frames", out_data_o.frames_available, w.frames_available);
        if (out_data_o.samples_written != w.samples_written)
          report_mismatch("written", out_data_o.samples_written, w.samples_written);
        if (out_data_o.error_code != w.error_code)
          report_mismatch("error_code", out_data_o.error_code, w.error_code);
      end
    end
  end

  always @(negedge clk_i) out_stall_i <= !calm && ($urandom_range(0, 99) < 28);

  task automatic send_byte(logic [7:0] b, bit first, bit last);
    wsmd_in_t d;
    int       target;
    d.data_byte = b; d.first_byte = first; d.last_byte = last;
    if (!calm && $urandom_range(0, 99) < 28) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    target = in_taken + 1;
    in_valid_i <= 1'b1;
    in_data_i <= d;
    while (in_taken != target) @(negedge clk_i);
    decode_byte(d);
    bytes_sent++;
  endtask

  task automatic push_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) wav_q.push_back(v[8*i +: 8]);
  endtask

  // builds a file; extra adds stray bytes after the whole frames
  task automatic build_wav(logic [15:0] code, logic [15:0] sub, int nch, int nbits,
                           int fmt_len, int frames, int extra, bit junk, bit has_fmt);
    int          data_len;
    logic [31:0] v;
    wav_q.delete();
    push_le("FFIR", 4); push_le($urandom, 4); push_le("EVAW", 4);
    if (junk) begin
      int jl;
      jl = $urandom_range(0, 5);
      push_le("KNUJ", 4); push_le(jl, 4);
      repeat (jl + jl % 2) wav_q.push_back(8'($urandom));
    end
    if (has_fmt) begin
      push_le(TAG_FMT, 4); push_le(fmt_len, 4);
      for (int i = 0; i < fmt_len + fmt_len % 2; i++) begin
        case (i)
          0, 1:   v = code >> (8 * i);
          2, 3:   v = nch >> (8 * (i - 2));
          4:      v = 8'h44; 5: v = 8'hAC;
          6, 7:   v = $urandom_range(0, 1) ? 0 : $urandom;
          14, 15: v = nbits >> (8 * (i - 14));
          24, 25: v = sub >> (8 * (i - 24));
          default: v = $urandom;
        endcase
        wav_q.push_back(v[7:0]);
      end
    end
    data_len = frames * (nbits / 8) * nch + extra;
    push_le(TAG_DATA, 4); push_le(data_len, 4);
    for (int i = 0; i < data_len; i++) begin
      if (code == FMT_FLOAT && i % 4 == 3 && $urandom_range(0, 1))
        v = {24'd0, 1'($urandom_range(0, 1)), 7'($urandom_range(50, 70))};
      else case ($urandom_range(0, 7))
        0: v = 8'h00; 1: v = 8'hFF; 2: v = 8'h80; 3: v = 8'h7F; default: v = $urandom;
      endcase
      wav_q.push_back(v[7:0]);
    end
  endtask

  // cut of zero sends all; no_end leaves last_byte low throughout
  task automatic send_file(int cut, bit no_end);
    int n;
    n = (cut > 0 && cut < wav_q.size()) ? cut : wav_q.size();
    for (int i = 0; i < n; i++) send_byte(wav_q[i], i == 0, (i == n - 1) && !no_end);
  endtask

  task automatic wait_drained();
    while (decoded_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_sample_cap(logic [23:0] v);
    in_valid_i <= 1'b0;
    wait_drained();
    cfg_we_i <= 1'b1; cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sample_cap = v;
  endtask

  task automatic test_header_errors();
    wav_q = '{"R", "I", "F", "X"};
    send_file(0, 1);
    wav_q = '{"R", "I", "F", "F", 8'hFF, 8'h00, 8'hFF, 8'h00, "W", "A", "V", "F"};
    send_file(0, 1);
    wav_q = '{"R", "I"};
    send_file(0, 0);
  endtask

  task automatic test_pcm_depths();
    build_wav(FMT_PCM, 0, 1, 8, 16, 3, 0, 0, 1);  send_file(0, 0);
    build_wav(FMT_PCM, 0, 2, 16, 18, 2, 1, 1, 1); send_file(0, 0);
    build_wav(FMT_PCM, 0, 3, 24, 17, 2, 0, 0, 1); send_file(0, 0);
    build_wav(FMT_PCM, 0, 2, 32, 16, 2, 0, 0, 1); send_file(0, 0);
  endtask

  task automatic test_float_and_extensible();
    build_wav(FMT_FLOAT, 0, 2, 32, 16, 4, 0, 0, 1);      send_file(0, 0);
    build_wav(FMT_EXT, FMT_FLOAT, 1, 32, 40, 3, 0, 0, 1); send_file(0, 0);
    build_wav(FMT_EXT, FMT_PCM, 1, 16, 41, 2, 0, 1, 1);   send_file(0, 0);
    build_wav(FMT_EXT, FMT_PCM, 1, 16, 24, 1, 0, 0, 1);   send_file(0, 0);
  endtask

  task automatic test_structure_errors();
    build_wav(FMT_PCM, 0, 1, 16, 16, 2, 0, 0, 0);   send_file(0, 0);
    build_wav(FMT_PCM, 0, 200, 24, 16, 0, 1, 0, 1); send_file(0, 0);
    build_wav(FMT_PCM, 0, 1, 12, 16, 1, 0, 0, 1);   send_file(0, 0);
    build_wav(FMT_PCM, 0, 0, 16, 16, 1, 0, 0, 1);   send_file(0, 0);
    build_wav(FMT_PCM, 0, 1, 16, 16, 0, 1, 0, 1);   send_file(0, 0);
    build_wav(FMT_PCM, 0, 1, 16, 16, 3, 0, 0, 1);   send_file(16, 0);
    build_wav(FMT_PCM, 0, 1, 16, 16, 3, 0, 0, 1);   send_file(25, 0);
    build_wav(FMT_PCM, 0, 2, 16, 16, 3, 0, 0, 1);   send_file(wav_q.size() - 3, 0);
  endtask

  task automatic test_sample_limit();
    write_sample_cap(24'd0);
    build_wav(FMT_PCM, 0, 1, 8, 16, 3, 0, 0, 1); send_file(0, 0);
    write_sample_cap(24'd2);
    build_wav(FMT_PCM, 0, 2, 8, 16, 5, 0, 0, 1); send_file(0, 0);
    write_sample_cap(24'hFFFFFF);
  endtask

  task automatic test_random_files();
    logic [15:0] codes[4] = '{FMT_PCM, FMT_FLOAT, FMT_EXT, 16'h0000};
    int          depths[4] = '{8, 16, 24, 32};
    int          start;
    start = bytes_sent;
    while (bytes_sent - start < 150) begin
      int          pick, nbits, nch;
      logic [15:0] code;
      calm = (bytes_sent - start > 30 && bytes_sent - start < 110);
      pick = $urandom_range(0, 11);
      nch = $urandom_range(1, 3);
      nbits = depths[$urandom_range(0, 3)];
      code = (pick < 4) ? FMT_PCM : codes[$urandom_range(0, 2)];
      if (code != FMT_PCM) nbits = 32;
      if (pick == 8) begin
        code = 16'($urandom); nbits = $urandom_range(0, 40); nch = $urandom_range(0, 300);
      end
      build_wav(code, (code == FMT_EXT) ? FMT_PCM : 16'($urandom), nch, nbits,
                $urandom_range(0, 3) ? 16 : $urandom_range(14, 44),
                (pick == 8) ? 0 : $urandom_range(0, 5),
                $urandom_range(0, 3), $urandom_range(0, 1), pick != 9);
      case (pick)
        10: wav_q[$urandom_range(0, 11)] ^= 8'(1 << $urandom_range(0, 7));
        11: repeat ($urandom_range(3, 12)) wav_q.insert($urandom_range(1, 8), 8'($urandom));
        default: ;
      endcase
      send_file((pick == 7) ? $urandom_range(1, wav_q.size()) : 0, $urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) send_byte(8'($urandom), 0, $urandom_range(0, 1));
    end
    calm = 0;
    write_sample_cap($urandom_range(1, 4));
    repeat (2) begin
      build_wav(FMT_PCM, 0, 1, 16, 16, $urandom_range(0, 6), 0, 0, 1);
      send_file(0, 0);
    end
    write_sample_cap(24'hFFFFFF);
  endtask

  initial begin
    clear_state();
    sample_cap = 24'hFFFFFF;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_header_errors();
    test_pcm_depths();
    test_float_and_extensible();
    test_structure_errors();
    test_sample_limit();
    test_random_files();
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("wav_stream_mono_decoder_unit test passed");
    end else begin
      $display("wav_stream_mono_decoder_unit test failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("wav_stream_mono_decoder_unit test failed");
    $finish;
  end

endmodule
